// ----- sv/cce_pkg.sv -----
// Package for the cluster chain to extents block: register indexes, status codes,
// fixed field widths and the control structs shared between the submodules.
// No dependencies.
package cce_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CSZ_BITS   = 22;
    localparam int FSIZE_BITS = 32;

    localparam logic [CSZ_BITS-1:0] CSZ_RESET = 22'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_OFFSET  = 2'd0,
        CFG_CLUSTER_SIZE = 2'd1,
        CFG_FILE_SIZE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OVER  = 2'd2,
        ST_TRIM  = 2'd3
    } t_status;

    // Occupancy of a pipeline slot.
    typedef struct packed {
        logic valid;
        logic last;
    } t_item_ctl;

    // Results offered to the output queue in one cycle, first and second in order.
    typedef struct packed {
        logic first;
        logic second;
    } t_push_ctl;

endpackage

// ----- sv/cce_item_if.sv -----
// Input channel of the cluster chain to extents block: one cluster of the chain per
// transaction. Stand-alone, no package needed.
interface cce_item_if #(
    parameter int CLUSTER_BITS = 28
);
    logic                    valid;
    logic                    ready;
    logic [CLUSTER_BITS-1:0] cluster_number;
    logic                    chain_end;

    modport source (output valid, cluster_number, chain_end, input ready);
    modport sink   (input valid, cluster_number, chain_end, output ready);
endinterface

// ----- sv/cce_run_if.sv -----
// Output channel of the cluster chain to extents block: one device extent per
// transaction. Stand-alone, no package needed.
interface cce_run_if #(
    parameter int OFFSET_BITS = 64
);
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] run_start;
    logic [OFFSET_BITS-1:0] run_bytes;
    logic                   final_run;
    logic [1:0]             status;

    modport source (output valid, run_start, run_bytes, final_run, status, input ready);
    modport sink   (input valid, run_start, run_bytes, final_run, status, output ready);
endinterface

// ----- sv/cluster_chain_to_extents.sv -----
// Turns a FAT32 cluster chain, one cluster per input transaction, into device byte
// extents. It takes one cluster every cycle while input ready is high; an item passes
// stages s1 to s5 and the output queue before its first result appears. A cluster
// that breaks the open run, or the final cluster, yields a result, and a final
// cluster that also breaks the run yields two, closed run first. The output gives one
// result per cycle from a four-entry queue, and input ready drops while it holds
// three or more results, so the sustained rate is one item per cycle as long as the
// sink takes one result per cycle and items average at most one result. Configuration
// takes effect for items accepted at the clock edge of the write or later; the user
// must write it only while no item is in flight, which the block does not enforce.
// Depends on cce_pkg, cce_item_if, cce_run_if and the cce_ submodules.
module cluster_chain_to_extents import cce_pkg::*; #(
    parameter int OFFSET_BITS  = 64,
    parameter int CLUSTER_BITS = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cce_item_if.sink              i_item,
    cce_run_if.source             o_result
);

    localparam int ENTRY_W = 2 * OFFSET_BITS + 3;

    logic [CSZ_BITS-1:0]    cluster_size;
    logic [FSIZE_BITS-1:0]  file_size;
    logic [OFFSET_BITS-1:0] base;
    logic [OFFSET_BITS-1:0] base_plus;
    logic                   adv;
    t_item_ctl              off_ctl;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] offset_plus;
    t_push_ctl              push;
    logic [ENTRY_W-1:0]     entry0;
    logic [ENTRY_W-1:0]     entry1;
    logic [ENTRY_W-1:0]     q_entry;

    cce_cfg #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (i_cfg_we),
        .i_index        (i_cfg_index),
        .i_data         (i_cfg_data),
        .o_cluster_size (cluster_size),
        .o_file_size    (file_size),
        .o_base         (base),
        .o_base_plus    (base_plus)
    );

    cce_offset #(
        .OFFSET_BITS  (OFFSET_BITS),
        .CLUSTER_BITS (CLUSTER_BITS)
    ) u_offset (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_valid          (i_item.valid),
        .i_cluster_number (i_item.cluster_number),
        .i_chain_end      (i_item.chain_end),
        .i_cluster_size   (cluster_size),
        .i_base           (base),
        .i_base_plus      (base_plus),
        .o_ctl            (off_ctl),
        .o_offset         (offset),
        .o_offset_plus    (offset_plus)
    );

    cce_runs #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_runs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_ctl          (off_ctl),
        .i_offset       (offset),
        .i_offset_plus  (offset_plus),
        .i_cluster_size (cluster_size),
        .i_file_size    (file_size),
        .o_push         (push),
        .o_entry0       (entry0),
        .o_entry1       (entry1)
    );

    cce_outq #(
        .WIDTH (ENTRY_W)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry0 (entry0),
        .i_entry1 (entry1),
        .o_adv    (adv),
        .o_valid  (o_result.valid),
        .o_entry  (q_entry),
        .i_ready  (o_result.ready)
    );

    assign i_item.ready = adv;
    assign {o_result.run_start, o_result.run_bytes, o_result.final_run, o_result.status} =
        q_entry;

endmodule

// ----- sv/cce_cfg.sv -----
// Configuration registers and the precomputed offset bases derived from them.
// Depends on cce_pkg.
module cce_cfg import cce_pkg::*; #(
    parameter int OFFSET_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [CFG_IDX_W-1:0]   i_index,
    input  logic [CFG_DATA_W-1:0]  i_data,
    output logic [CSZ_BITS-1:0]    o_cluster_size,
    output logic [FSIZE_BITS-1:0]  o_file_size,
    output logic [OFFSET_BITS-1:0] o_base,
    output logic [OFFSET_BITS-1:0] o_base_plus
);

    logic [OFFSET_BITS-1:0] r_data_offset;
    logic [CSZ_BITS-1:0]    r_cluster_size;
    logic [FSIZE_BITS-1:0]  r_file_size;
    logic [OFFSET_BITS-1:0] r_base;
    logic [OFFSET_BITS-1:0] r_base_plus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_offset  <= '0;
            r_cluster_size <= CSZ_RESET;
            r_file_size    <= '0;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_index))
                CFG_DATA_OFFSET:  r_data_offset  <= i_data[OFFSET_BITS-1:0];
                CFG_CLUSTER_SIZE: r_cluster_size <= i_data[CSZ_BITS-1:0];
                CFG_FILE_SIZE:    r_file_size    <= i_data[FSIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Cluster n sits at base + n * size, with base = data_offset - 2 * size.
    // The second base gives the end of that cluster without a second adder in series.
    always_ff @(posedge i_clk) begin
        r_base      <= r_data_offset - OFFSET_BITS'({r_cluster_size, 1'b0});
        r_base_plus <= r_data_offset - OFFSET_BITS'(r_cluster_size);
    end

    assign o_cluster_size = r_cluster_size;
    assign o_file_size    = r_file_size;
    assign o_base         = r_base;
    assign o_base_plus    = r_base_plus;

endmodule

// ----- sv/cce_offset.sv -----
// Front of the pipeline: input register, cluster times size multiply, and the device
// offset of the cluster and of its end. Depends on cce_pkg.
module cce_offset import cce_pkg::*; #(
    parameter int OFFSET_BITS  = 64,
    parameter int CLUSTER_BITS = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [CLUSTER_BITS-1:0] i_cluster_number,
    input  logic                    i_chain_end,
    input  logic [CSZ_BITS-1:0]     i_cluster_size,
    input  logic [OFFSET_BITS-1:0]  i_base,
    input  logic [OFFSET_BITS-1:0]  i_base_plus,
    output t_item_ctl               o_ctl,
    output logic [OFFSET_BITS-1:0]  o_offset,
    output logic [OFFSET_BITS-1:0]  o_offset_plus
);

    localparam int PROD_W = CLUSTER_BITS + CSZ_BITS;

    t_item_ctl               r_s1_ctl;
    logic [CLUSTER_BITS-1:0] r_s1_cluster;
    t_item_ctl               r_s2_ctl;
    logic [PROD_W-1:0]       r_s2_prod;
    t_item_ctl               r_s3_ctl;
    logic [OFFSET_BITS-1:0]  r_s3_offset;
    logic [OFFSET_BITS-1:0]  r_s3_offset_plus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else if (i_adv) begin
            r_s1_ctl <= '{valid: i_valid, last: i_chain_end};
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    // Arithmetic wraps modulo the offset width, so the product is simply resized to it.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_cluster     <= i_cluster_number;
            r_s2_prod        <= PROD_W'(r_s1_cluster) * PROD_W'(i_cluster_size);
            r_s3_offset      <= i_base + OFFSET_BITS'(r_s2_prod);
            r_s3_offset_plus <= i_base_plus + OFFSET_BITS'(r_s2_prod);
        end
    end

    assign o_ctl         = r_s3_ctl;
    assign o_offset      = r_s3_offset;
    assign o_offset_plus = r_s3_offset_plus;

endmodule

// ----- sv/cce_runs.sv -----
// Run tracking: extends or closes the open run, keeps the allocation total, and
// builds the closed and final extents with tail trimming. Depends on cce_pkg.
module cce_runs import cce_pkg::*; #(
    parameter int OFFSET_BITS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  t_item_ctl                  i_ctl,
    input  logic [OFFSET_BITS-1:0]     i_offset,
    input  logic [OFFSET_BITS-1:0]     i_offset_plus,
    input  logic [CSZ_BITS-1:0]        i_cluster_size,
    input  logic [FSIZE_BITS-1:0]      i_file_size,
    output t_push_ctl                  o_push,
    output logic [2*OFFSET_BITS+2:0]   o_entry0,
    output logic [2*OFFSET_BITS+2:0]   o_entry1
);

    localparam int OB = OFFSET_BITS;

    // Open run and allocation total.
    logic          r_run_valid;
    logic [OB-1:0] r_start;
    logic [OB-1:0] r_len;
    logic [OB-1:0] r_end;
    logic [OB-1:0] r_alloc;

    logic          n_run_valid;
    logic [OB-1:0] n_start;
    logic [OB-1:0] n_len;
    logic [OB-1:0] n_end;
    logic [OB-1:0] n_alloc;

    logic          fs_nz;
    logic          match;
    logic          closed_v;
    logic          len_c;
    logic          alloc_c;
    logic [OB-1:0] len_sum;
    logic [OB-1:0] alloc_sum;
    logic [OB-1:0] csz_w;
    logic [OB-1:0] fs_w;

    // Stage after the update: closed run and raw final run.
    logic          r_s4_closed;
    logic          r_s4_fin;
    logic [OB-1:0] r_s4_cstart;
    logic [OB-1:0] r_s4_clen;
    logic          r_s4_empty;
    logic [OB-1:0] r_s4_start;
    logic [OB-1:0] r_s4_len;
    logic [OB-1:0] r_s4_alloc;

    // Stage with the slack worked out.
    logic          r_s5_closed;
    logic          r_s5_fin;
    logic [OB-1:0] r_s5_cstart;
    logic [OB-1:0] r_s5_clen;
    logic          r_s5_empty;
    logic          r_s5_over;
    logic [OB-1:0] r_s5_start;
    logic [OB-1:0] r_s5_len;
    logic [OB-1:0] r_s5_slack;

    logic [OB-1:0] fin_start;
    logic [OB-1:0] fin_bytes;
    t_status       fin_status;
    logic [2*OB+2:0] closed_entry;
    logic [2*OB+2:0] fin_entry;

    assign csz_w = OB'(i_cluster_size);
    assign fs_w  = OB'(i_file_size);
    assign fs_nz = (i_file_size != '0);
    assign match = r_run_valid && (i_offset == r_end);

    assign {len_c, len_sum}     = {1'b0, r_len} + {1'b0, csz_w};
    assign {alloc_c, alloc_sum} = {1'b0, r_alloc} + {1'b0, csz_w};

    always_comb begin
        n_run_valid = r_run_valid;
        n_start     = r_start;
        n_len       = r_len;
        n_end       = r_end;
        n_alloc     = r_alloc;
        closed_v    = 1'b0;
        if (fs_nz) begin
            if (match) begin
                // A saturated length puts the end one below the start, modulo the width.
                n_len = len_c ? '1 : len_sum;
                n_end = len_c ? (r_start - OB'(1)) : i_offset_plus;
            end else begin
                closed_v    = r_run_valid;
                n_start     = i_offset;
                n_len       = csz_w;
                n_end       = i_offset_plus;
                n_run_valid = 1'b1;
            end
            n_alloc = alloc_c ? '1 : alloc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_start     <= '0;
            r_len       <= '0;
            r_end       <= '0;
            r_alloc     <= '0;
        end else if (i_adv && i_ctl.valid) begin
            if (i_ctl.last) begin
                r_run_valid <= 1'b0;
                r_start     <= '0;
                r_len       <= '0;
                r_end       <= '0;
                r_alloc     <= '0;
            end else begin
                r_run_valid <= n_run_valid;
                r_start     <= n_start;
                r_len       <= n_len;
                r_end       <= n_end;
                r_alloc     <= n_alloc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_closed <= 1'b0;
            r_s4_fin    <= 1'b0;
            r_s5_closed <= 1'b0;
            r_s5_fin    <= 1'b0;
        end else if (i_adv) begin
            r_s4_closed <= i_ctl.valid && closed_v;
            r_s4_fin    <= i_ctl.valid && i_ctl.last;
            r_s5_closed <= r_s4_closed;
            r_s5_fin    <= r_s4_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s4_cstart <= r_start;
            r_s4_clen   <= r_len;
            r_s4_empty  <= !fs_nz;
            r_s4_start  <= n_start;
            r_s4_len    <= n_len;
            r_s4_alloc  <= n_alloc;

            r_s5_cstart <= r_s4_cstart;
            r_s5_clen   <= r_s4_clen;
            r_s5_empty  <= r_s4_empty;
            r_s5_over   <= fs_w > r_s4_alloc;
            r_s5_start  <= r_s4_start;
            r_s5_len    <= r_s4_len;
            r_s5_slack  <= r_s4_alloc - fs_w;
        end
    end

    always_comb begin
        fin_start  = r_s5_start;
        fin_bytes  = r_s5_len;
        fin_status = ST_OK;
        if (r_s5_empty) begin
            fin_start  = '0;
            fin_bytes  = '0;
            fin_status = ST_EMPTY;
        end else if (r_s5_over) begin
            fin_status = ST_OVER;
        end else if (r_s5_slack > r_s5_len) begin
            fin_bytes  = '0;
            fin_status = ST_TRIM;
        end else begin
            fin_bytes = r_s5_len - r_s5_slack;
        end
    end

    assign closed_entry = {r_s5_cstart, r_s5_clen, 1'b0, ST_OK};
    assign fin_entry    = {fin_start, fin_bytes, 1'b1, fin_status};

    assign o_push.first  = r_s5_closed || r_s5_fin;
    assign o_push.second = r_s5_closed && r_s5_fin;
    assign o_entry0      = r_s5_closed ? closed_entry : fin_entry;
    assign o_entry1      = fin_entry;

endmodule

// ----- sv/cce_outq.sv -----
// Output queue of four extents that takes up to two per cycle and gives one, and
// holds the pipeline while it cannot take two more. Depends on cce_pkg.
module cce_outq import cce_pkg::*; #(
    parameter int WIDTH = 131
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push_ctl        i_push,
    input  logic [WIDTH-1:0] i_entry0,
    input  logic [WIDTH-1:0] i_entry1,
    output logic             o_adv,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_entry,
    input  logic             i_ready
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    logic push0;
    logic push1;
    logic pop;

    assign o_adv   = (r_count <= CW'(DEPTH - 2));
    assign push0   = o_adv && i_push.first;
    assign push1   = o_adv && i_push.second;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (push1) begin
            r_mem[r_wr + AW'(1)] <= i_entry1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(push0) + AW'(push1);
            r_rd    <= r_rd + AW'(pop);
            r_count <= r_count + CW'(push0) + CW'(push1) - CW'(pop);
        end
    end

endmodule

// ----- sv/cce_checker.sv -----
// Port-level checks on the result channel of cluster_chain_to_extents, bound to
// the top level. Depends on cce_pkg.
module cce_checker import cce_pkg::*; #(
    parameter int OFFSET_BITS = 64
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   i_ready,
    input logic [OFFSET_BITS-1:0] i_run_start,
    input logic [OFFSET_BITS-1:0] i_run_bytes,
    input logic                   i_final_run,
    input logic [1:0]             i_status
);

    // Only the last extent of a chain carries a status other than ok.
    a_nonfinal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_final_run) |-> (i_status == ST_OK))
        else $error("non-final extent with a status other than ok");

    // An empty file gives one zero extent that ends the chain.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_EMPTY)) |->
            (i_final_run && (i_run_start == '0) && (i_run_bytes == '0)))
        else $error("empty-file extent is not a zero final extent");

    // An over-long trim saturates the extent to zero bytes.
    a_trim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_TRIM)) |-> (i_final_run && (i_run_bytes == '0)))
        else $error("trimmed extent is not saturated to zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_run_start) && $stable(i_run_bytes)
             && $stable(i_final_run) && $stable(i_status)))
        else $error("stalled extent changed or dropped");

endmodule

bind cluster_chain_to_extents cce_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_cce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_result.valid),
    .i_ready     (o_result.ready),
    .i_run_start (o_result.run_start),
    .i_run_bytes (o_result.run_bytes),
    .i_final_run (o_result.final_run),
    .i_status    (o_result.status)
);
